### sv/modbus_rtu_response_receiver_defines.svh
// Assertion macros for the checker file of the Modbus RTU receiver.
// No dependencies; include by bare file name.
`ifndef MODBUS_RTU_RESPONSE_RECEIVER_DEFINES_SVH
`define MODBUS_RTU_RESPONSE_RECEIVER_DEFINES_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define MRR_ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define MRR_ASSERT(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/mrr_pkg.sv
// Types, constants and the CRC-16 byte update for the Modbus RTU receiver.
// No dependencies; compile first.
package mrr_pkg;

  // Longest frame; a frame ends when the byte counter reaches it
  localparam int MAX_FRAME = 256;
  localparam int TOTAL_W   = $clog2(MAX_FRAME + 1);
  // Compare width wide enough for 5 + byte count and for MAX_FRAME
  localparam int CMP_W     = (TOTAL_W > 10) ? TOTAL_W : 10;
  localparam int LEN_W     = 9;

  localparam logic [15:0]      CRC_INIT      = 16'hFFFF;
  localparam logic [15:0]      CRC_POLY      = 16'hA001;
  localparam logic [7:0]       FC_READ_HOLD  = 8'h03;
  localparam logic [7:0]       FC_WRITE_COIL = 8'h05;
  localparam logic [LEN_W-1:0] MIN_LEN_RST   = LEN_W'(8);
  localparam int               COIL_LEN      = 6;
  localparam int               READ_OVERHEAD = 5;

  typedef enum logic {
    CMD_BYTE    = 1'b0,
    CMD_TIMEOUT = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CRC_ERR = 2'd1,
    ST_NO_RESP = 2'd2
  } status_e;

  typedef struct packed {
    status_e          status;
    logic [LEN_W-1:0] frame_length;
    logic [7:0]       slave_address;
    logic [7:0]       function_code;
    logic [7:0]       data_count;
    logic [15:0]      received_crc;
    logic [15:0]      computed_crc;
  } res_t;

  // Fold one byte into a reflected CRC-16
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### sv/mrr_in_if.sv
// Input channel of the Modbus RTU receiver: received byte or idle timeout.
// Standalone; no package needed.
interface mrr_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

### sv/mrr_out_if.sv
// Result channel of the Modbus RTU receiver: one word per finished frame.
// Standalone; no package needed.
interface mrr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [8:0]  frame_length;
  logic [7:0]  slave_address;
  logic [7:0]  function_code;
  logic [7:0]  data_count;
  logic [15:0] received_crc;
  logic [15:0] computed_crc;

  modport source (output valid, output status, output frame_length, output slave_address,
                  output function_code, output data_count, output received_crc,
                  output computed_crc, input ready);
  modport sink   (input valid, input status, input frame_length, input slave_address,
                  input function_code, input data_count, input received_crc,
                  input computed_crc, output ready);
endinterface

### sv/mrr_cfg_if.sv
// Configuration write channel of the Modbus RTU receiver (CRC minimum length).
// Standalone; no package needed.
interface mrr_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/modbus_rtu_response_receiver.sv
// Modbus RTU response receiver. Accepts one word per clock: a received byte or an
// idle-timeout event. Byte count, address, function code, byte-count field, the
// last two bytes and a CRC-16 lagging two bytes behind are updated in the cycle
// the word is accepted (the byte-wide CRC fold is the longest path). A word that
// ends a frame has its result registered into the output buffer on acceptance. A
// two-entry output buffer lets input continue while a result waits; input stalls
// only while both entries are full. Depends on mrr_pkg and the mrr_*_if interfaces.
module modbus_rtu_response_receiver (
  input  logic       clk_i,
  input  logic       rst_ni,
  mrr_cfg_if.sink    cfg_i,
  mrr_in_if.sink     in_i,
  mrr_out_if.source  out_o
);
  import mrr_pkg::*;

  logic [LEN_W-1:0]   min_len_q;
  logic [TOTAL_W-1:0] total_q, total_d, total_inc;
  logic [7:0]         addr_q, addr_d, func_q, func_d, count_q, count_d;
  logic [15:0]        tail_q, tail_d, lag_q, lag_d;

  logic [TOTAL_W-1:0] f_total;
  logic [7:0]         f_addr, f_func, f_count;
  logic [15:0]        f_tail, f_lag;
  logic [CMP_W-1:0]   f_total_w;
  logic               accept, done;
  res_t               res;

  res_t head_q, skid_q;
  logic head_vld_q, skid_vld_q, pop;

  // Configuration register, always ready
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= MIN_LEN_RST;
    end else if (cfg_i.valid) begin
      min_len_q <= cfg_i.data;
    end
  end

  assign accept    = in_i.valid && in_i.ready;
  assign total_inc = total_q + TOTAL_W'(1);

  // Frame update for one word; f_* is the frame as it stands after the word
  always_comb begin
    f_total = total_q;
    f_addr  = addr_q;
    f_func  = func_q;
    f_count = count_q;
    f_tail  = tail_q;
    f_lag   = lag_q;
    done    = 1'b1;
    if (in_i.command == CMD_BYTE) begin
      if (total_q >= TOTAL_W'(2)) begin
        f_lag = crc_fold(lag_q, tail_q[7:0]);
      end
      f_tail  = {in_i.data_byte, tail_q[15:8]};
      if (total_q == TOTAL_W'(0)) f_addr  = in_i.data_byte;
      if (total_q == TOTAL_W'(1)) f_func  = in_i.data_byte;
      if (total_q == TOTAL_W'(2)) f_count = in_i.data_byte;
      f_total = total_inc;
    end
    f_total_w = CMP_W'(f_total);
    if (in_i.command == CMD_BYTE) begin
      done = (f_total_w >= CMP_W'(3) && f_func == FC_READ_HOLD &&
              f_total_w >= CMP_W'(READ_OVERHEAD) + CMP_W'(f_count)) ||
             (f_total_w >= CMP_W'(3) && f_func == FC_WRITE_COIL &&
              f_total_w >= CMP_W'(COIL_LEN)) ||
             (f_total_w >= CMP_W'(MAX_FRAME));
    end
  end

  // Result word for a finished frame
  always_comb begin
    res = '0;
    if (f_total == TOTAL_W'(0)) begin
      res.status = ST_NO_RESP;
    end else begin
      res.status = ST_OK;
      if (f_total_w >= CMP_W'(min_len_q) &&
          (f_total_w < CMP_W'(3) || f_tail != f_lag)) begin
        res.status = ST_CRC_ERR;
      end
      res.frame_length  = f_total_w[LEN_W-1:0];
      res.slave_address = f_addr;
      res.function_code = f_func;
      res.data_count    = f_count;
      res.received_crc  = f_tail;
      res.computed_crc  = f_lag;
    end
  end

  // Clear the frame when it ends, else keep the updated frame
  always_comb begin
    total_d = f_total;
    addr_d  = f_addr;
    func_d  = f_func;
    count_d = f_count;
    tail_d  = f_tail;
    lag_d   = f_lag;
    if (done) begin
      total_d = '0;
      addr_d  = '0;
      func_d  = '0;
      count_d = '0;
      tail_d  = '0;
      lag_d   = CRC_INIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      addr_q  <= '0;
      func_q  <= '0;
      count_q <= '0;
      tail_q  <= '0;
      lag_q   <= CRC_INIT;
    end else if (accept) begin
      total_q <= total_d;
      addr_q  <= addr_d;
      func_q  <= func_d;
      count_q <= count_d;
      tail_q  <= tail_d;
      lag_q   <= lag_d;
    end
  end

  // Two-entry output buffer: head drives the port, skid catches a stalled push
  assign pop        = head_vld_q && out_o.ready;
  assign in_i.ready = !skid_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!head_vld_q || pop) begin
      if (skid_vld_q) begin
        head_vld_q <= 1'b1;
        skid_vld_q <= accept && done;
      end else begin
        head_vld_q <= accept && done;
      end
    end else if (accept && done) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!head_vld_q || pop) begin
      if (skid_vld_q) begin
        head_q <= skid_q;
        if (accept && done) skid_q <= res;
      end else if (accept && done) begin
        head_q <= res;
      end
    end else if (accept && done) begin
      skid_q <= res;
    end
  end

  assign out_o.valid         = head_vld_q;
  assign out_o.status        = head_q.status;
  assign out_o.frame_length  = head_q.frame_length;
  assign out_o.slave_address = head_q.slave_address;
  assign out_o.function_code = head_q.function_code;
  assign out_o.data_count    = head_q.data_count;
  assign out_o.received_crc  = head_q.received_crc;
  assign out_o.computed_crc  = head_q.computed_crc;

endmodule

### sv/mrr_checker.sv
// Port-level checks for the Modbus RTU receiver, bound to its top level.
// Depends on mrr_pkg and modbus_rtu_response_receiver_defines.svh.
`include "modbus_rtu_response_receiver_defines.svh"

module mrr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  status_i,
  input logic [8:0]  frame_length_i,
  input logic [7:0]  slave_address_i,
  input logic [15:0] received_crc_i,
  input logic [15:0] computed_crc_i
);
  import mrr_pkg::*;

  // No-response words carry all-zero fields
  `MRR_ASSERT_RST(a_no_resp_zero, clk_i, rst_ni, (out_valid_i && status_i == ST_NO_RESP) |-> (frame_length_i == '0 && slave_address_i == '0 && received_crc_i == '0 && computed_crc_i == '0), "no-response word with nonzero fields")

  // Input stalls only while a result is pending
  `MRR_ASSERT_RST(a_stall_has_result, clk_i, rst_ni, (in_valid_i && !in_ready_i) |-> out_valid_i, "input stalled with empty output")

  // A stalled result holds
  `MRR_ASSERT_RST(a_out_hold, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(status_i) && $stable(frame_length_i) && $stable(computed_crc_i)), "stalled result changed")

  // Nothing is shown during reset
  `MRR_ASSERT(a_reset_idle, clk_i, !rst_ni |-> !out_valid_i, "output valid in reset")

endmodule

bind modbus_rtu_response_receiver mrr_checker u_mrr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .status_i        (out_o.status),
  .frame_length_i  (out_o.frame_length),
  .slave_address_i (out_o.slave_address),
  .received_crc_i  (out_o.received_crc),
  .computed_crc_i  (out_o.computed_crc)
);

### tb/sv/testbench.sv
// Self-checking testbench for the Modbus RTU response receiver: drives received bytes
// and idle timeouts, predicts every frame result and checks it on the result channel.
// Depends on mrr_pkg, the mrr_*_if interfaces and modbus_rtu_response_receiver.
module testbench;
  import mrr_pkg::*;

  localparam int HALF_PERIOD     = 6;
  localparam int RESET_CYCLES    = 12;
  localparam int MAX_WAIT        = 16;
  localparam int SETTLE_CYCLES   = 4;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int QUIET_LIMIT     = 2000;
  localparam int PHASE_WORDS     = 95;
  localparam int FULL_FRAME      = 1024;
  localparam int FLOOD_WORDS     = 40;
  localparam logic [7:0] FC_OTHER = 8'h10;

  typedef logic [7:0] octet_q_t[$];

  // Frame predictor and result scoreboard
  class frame_scoreboard;
    logic [LEN_W-1:0] min_len;
    int unsigned      n_bytes;
    logic [7:0]       addr_seen;
    logic [7:0]       func_seen;
    logic [7:0]       count_seen;
    logic [15:0]      tail_word;
    logic [15:0]      crc_acc;
    res_t             frames_due[$];
    int unsigned      mismatches;
    int unsigned      frames_checked;
    int unsigned      ok_frames;
    int unsigned      crc_errs;
    int unsigned      no_resp;

    function new();
      min_len        = MIN_LEN_RST;
      mismatches     = 0;
      frames_checked = 0;
      ok_frames      = 0;
      crc_errs       = 0;
      no_resp        = 0;
      restart();
    endfunction

    function void restart();
      n_bytes    = 0;
      addr_seen  = '0;
      func_seen  = '0;
      count_seen = '0;
      tail_word  = '0;
      crc_acc    = CRC_INIT;
    endfunction

    // Bit-serial reflected CRC-16, data enters at the low end
    static function logic [15:0] crc16_step(logic [15:0] acc, logic [7:0] octet);
      logic [15:0] s;
      logic        fb;
      s = acc;
      for (int i = 0; i < 8; i++) begin
        fb = s[0] ^ octet[i];
        s  = s >> 1;
        if (fb) s = s ^ CRC_POLY;
      end
      return s;
    endfunction

    function void set_min_length(logic [LEN_W-1:0] value);
      min_len = value;
    endfunction

    function int unsigned pending();
      return frames_due.size();
    endfunction

    function bit frame_open();
      return n_bytes != 0;
    endfunction

    // Advance the frame state by one accepted word; queue a result if the frame ends
    function void note_word(cmd_e cmd, logic [7:0] octet);
      res_t r;
      bit   done;
      if (cmd == CMD_BYTE) begin
        // CRC trails two bytes behind: fold the byte leaving the tail
        if (n_bytes >= 2) crc_acc = crc16_step(crc_acc, tail_word[7:0]);
        tail_word = {octet, tail_word[15:8]};
        case (n_bytes)
          0: addr_seen  = octet;
          1: func_seen  = octet;
          2: count_seen = octet;
          default: ;
        endcase
        n_bytes++;
        done = (n_bytes >= 3 && func_seen == FC_READ_HOLD &&
                n_bytes >= READ_OVERHEAD + count_seen) ||
               (n_bytes >= 3 && func_seen == FC_WRITE_COIL && n_bytes >= COIL_LEN) ||
               (n_bytes >= MAX_FRAME);
        if (!done) return;
      end
      if (n_bytes == 0) begin
        r        = '0;
        r.status = ST_NO_RESP;
      end else begin
        r.status = ST_OK;
        if (n_bytes >= min_len && (n_bytes < 3 || tail_word != crc_acc))
          r.status = ST_CRC_ERR;
        r.frame_length  = LEN_W'(n_bytes);
        r.slave_address = addr_seen;
        r.function_code = func_seen;
        r.data_count    = count_seen;
        r.received_crc  = tail_word;
        r.computed_crc  = crc_acc;
      end
      frames_due = {frames_due, r};
      restart();
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        mismatches++;
      end
    endfunction

    // Match one accepted result against the oldest expected frame
    function void check_frame(res_t seen);
      res_t want;
      frames_checked++;
      if (frames_due.size() == 0) begin
        $error("frame result with none pending: status %0d, length %0d",
               seen.status, seen.frame_length);
        mismatches++;
        return;
      end
      want = frames_due.pop_front();
      case (want.status)
        ST_OK:      ok_frames++;
        ST_CRC_ERR: crc_errs++;
        default:    no_resp++;
      endcase
      compare_field("status",        want.status,        seen.status);
      compare_field("frame_length",  want.frame_length,  seen.frame_length);
      compare_field("slave_address", want.slave_address, seen.slave_address);
      compare_field("function_code", want.function_code, seen.function_code);
      compare_field("data_count",    want.data_count,    seen.data_count);
      compare_field("received_crc",  want.received_crc,  seen.received_crc);
      compare_field("computed_crc",  want.computed_crc,  seen.computed_crc);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  mrr_cfg_if cfg_if();
  mrr_in_if  in_if();
  mrr_out_if out_if();

  modbus_rtu_response_receiver u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  frame_scoreboard sb = new();
  res_t            seen;
  int unsigned     words_sent;
  int unsigned     settings_done;
  bit              gaps_on;
  bit              stalls_on;
  bit              hold_off_req;

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  // Sample all three channels; check results before noting new words
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) sb.set_min_length(cfg_if.data);
      if (out_if.valid && out_if.ready) begin
        seen.status        = status_e'(out_if.status);
        seen.frame_length  = out_if.frame_length;
        seen.slave_address = out_if.slave_address;
        seen.function_code = out_if.function_code;
        seen.data_count    = out_if.data_count;
        seen.received_crc  = out_if.received_crc;
        seen.computed_crc  = out_if.computed_crc;
        sb.check_frame(seen);
      end
      if (in_if.valid && in_if.ready) sb.note_word(cmd_e'(in_if.command), in_if.data_byte);
    end
  end

  // End the run if no word moves on any channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  // Result side: random stall before each word, one long hold-off on request
  initial begin : result_sink
    int stall;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = stalls_on ? $urandom_range(0, MAX_WAIT) : 0;
      if (hold_off_req) begin
        stall        = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // Offer one word after a random gap; return at the falling edge after acceptance
  task automatic send_word(input cmd_e cmd, input logic [7:0] octet);
    int gap;
    gap = gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.command   <= cmd;
    in_if.data_byte <= octet;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    words_sent++;
    @(negedge clk_i);
  endtask

  // Hold the input until every expected frame has come out, then let the block settle
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_min_length(input logic [LEN_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    settings_done++;
  endtask

  // Append the CRC (optionally damaged) and send the first keep bytes
  task automatic send_frame(input octet_q_t body, input bit corrupt, input int keep);
    logic [15:0] crc;
    crc = CRC_INIT;
    foreach (body[i]) crc = frame_scoreboard::crc16_step(crc, body[i]);
    if (corrupt) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
    body = {body, crc[7:0]};
    body = {body, crc[15:8]};
    foreach (body[i]) begin
      if (i < keep) send_word(CMD_BYTE, body[i]);
    end
  endtask

  // Close a partial frame with an idle timeout
  task automatic close_frame();
    if (sb.frame_open()) send_word(CMD_TIMEOUT, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_random_frame();
    octet_q_t body;
    int       pick;
    int       len;
    int       keep;
    bit       corrupt;
    pick    = $urandom_range(0, 99);
    corrupt = ($urandom_range(0, 3) == 0);
    body = {body, 8'($urandom_range(0, 255))};
    if (pick < 65) begin
      if (pick < 40) begin
        // read response: mostly short, now and then up to the maximum frame length
        len = ($urandom_range(0, 79) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 8);
        body = {body, FC_READ_HOLD};
        body = {body, 8'(len)};
        repeat (len) body = {body, 8'($urandom_range(0, 255))};
      end else begin
        body = {body, FC_WRITE_COIL};
        repeat (COIL_LEN - 4) body = {body, 8'($urandom_range(0, 255))};
      end
      // cut about a fifth of the well-formed frames short
      keep = ($urandom_range(0, 4) == 0) ? $urandom_range(1, body.size() + 1) : FULL_FRAME;
      send_frame(body, corrupt, keep);
    end else if (pick < 92) begin
      repeat ($urandom_range(1, 12)) send_word(CMD_BYTE, 8'($urandom_range(0, 255)));
    end else begin
      send_word(CMD_TIMEOUT, 8'($urandom_range(0, 255)));
    end
    close_frame();
  endtask

  initial begin
    octet_q_t    body;
    int          min_lengths[10];
    int unsigned phase_start;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.command   = CMD_BYTE;
    in_if.data_byte = 8'h00;
    cfg_if.valid    = 1'b0;
    cfg_if.data     = '0;
    words_sent      = 0;
    settings_done   = 0;
    gaps_on         = 1'b1;
    stalls_on       = 1'b1;
    hold_off_req    = 1'b0;
    min_lengths     = '{0, 1, 2, 3, 6, 9, 255, 256, 0, 8};
    min_lengths[8]  = $urandom_range(0, 256);
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: idle timeout, one- and two-byte frames, short and checked frames
    send_word(CMD_TIMEOUT, 8'h00);
    send_word(CMD_BYTE, 8'hFF);
    send_word(CMD_TIMEOUT, 8'hFF);
    send_word(CMD_BYTE, 8'h00);
    send_word(CMD_BYTE, 8'h80);
    send_word(CMD_TIMEOUT, 8'h5A);
    body = {8'h11, FC_READ_HOLD, 8'h00};
    send_frame(body, 1'b0, FULL_FRAME);
    body = {8'hF7, FC_WRITE_COIL, 8'h00, 8'hAC};
    send_frame(body, 1'b1, FULL_FRAME);
    body = {8'h01, FC_READ_HOLD, 8'h03, 8'h12, 8'h34, 8'h56};
    send_frame(body, 1'b0, FULL_FRAME);

    // Run the byte counter up to MAX_FRAME with a frame of unknown function
    send_word(CMD_BYTE, 8'($urandom_range(0, 255)));
    send_word(CMD_BYTE, FC_OTHER);
    repeat (MAX_FRAME - 2) send_word(CMD_BYTE, 8'($urandom_range(0, 255)));
    close_frame();

    // Random phases, one minimum-length setting each
    foreach (min_lengths[p]) begin
      drain();
      write_min_length(LEN_W'(min_lengths[p]));
      gaps_on   = (p % 3 != 1);
      stalls_on = (p % 3 != 2);
      if (p == 4) begin
        // flood timeouts while the result side holds off
        gaps_on      = 1'b0;
        hold_off_req = 1'b1;
        repeat (FLOOD_WORDS) send_word(CMD_TIMEOUT, 8'($urandom_range(0, 255)));
        drain();
        gaps_on = 1'b1;
      end
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS) send_random_frame();
    end

    drain();
    $display("Run covered %0d input words and %0d frame results over %0d length settings",
             words_sent, sb.frames_checked, settings_done);
    $display("Frame results: %0d ok, %0d CRC mismatch, %0d no response, %0d field mismatches",
             sb.ok_frames, sb.crc_errs, sb.no_resp, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### modbus_rtu_response_receiver.f
+incdir+sv
sv/mrr_pkg.sv
sv/mrr_in_if.sv
sv/mrr_out_if.sv
sv/mrr_cfg_if.sv
sv/modbus_rtu_response_receiver.sv
sv/mrr_checker.sv
tb/sv/testbench.sv
